// ===== rtl/lpht_pkg.sv =====
package lpht_pkg;

  // Table geometry
  localparam int SLOTS     = 16;
  localparam int KEY_BYTES = 8;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int KEY_W   = 64;
  localparam int VALUE_W = 32;
  localparam int ENTRY_W = KEY_W + VALUE_W;
  localparam int PROBE_W = 5;
  localparam int OUT_SLOT_W = 4;

  // Byte sum of a key, and the reciprocal used to reduce it modulo SLOTS
  localparam int SUM_W = $clog2(8 * 255 + 1);
  localparam int RECIP = (1 << SUM_W) / SLOTS;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

  // Request opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FOUND    = 2'd1;
  localparam logic [1:0] ST_MISSING  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Low bits of a slot index, zero-extended when the index is narrower
  function automatic logic [OUT_SLOT_W-1:0] slot_out(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+OUT_SLOT_W-1:0] ext;
    ext = {{OUT_SLOT_W{1'b0}}, idx};
    return ext[OUT_SLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/lpht_ram.sv =====
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// Open-addressing hash table with linear probing, SLOTS entries of a 64-bit
// key and a 32-bit value. A request is an insert (opcode 0) or a search
// (opcode 1); each request yields exactly one result. The home slot is the
// sum of the key bytes modulo SLOTS. An insert stores the pair in the first
// free slot from the home slot on (duplicates are stored again) or reports
// table full; a search reports the value of the first matching entry, or not
// found on a free slot or after one full wrap, plus the number of key
// comparisons. One request is in flight at a time. After acceptance the
// byte sum is registered, the quotient and then the home slot are formed,
// and the walk starts there. A search reads the entry of each occupied slot
// before comparing it; a free home slot misses without a read. Keys and
// values sit in one single-port-read memory, read one slot per cycle while
// the output is not stalled. Occupancy marks live in flip-flops and clear at
// reset, so the table is usable as soon as reset ends. The next request is
// taken in the cycle after a result is loaded into the output register; a
// stalled output holds the walk until the output register frees up.
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [KEY_W-1:0]      in_key,
  input  logic [VALUE_W-1:0]    in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [VALUE_W-1:0]    out_found_value,
  output logic [PROBE_W-1:0]    out_probe_count,
  output logic [OUT_SLOT_W-1:0] out_slot
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HASH  = 6'b000010,
    S_MOD   = 6'b000100,
    S_INS   = 6'b001000,
    S_PROBE = 6'b010000,
    S_CMP   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Request registers
  logic               op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;

  // Home slot reduction
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [2*SUM_W-1:0] recip_prod;
  logic [SUM_W-1:0]   rem_raw;
  logic [SUM_W-1:0]   rem_fix;
  logic [SUM_W-1:0]   byte_sum;

  // Walk registers
  logic [SLOT_W-1:0]  idx_r, idx_nxt;
  logic [SLOT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROBE_W-1:0] probes_r, probes_nxt;
  logic [SLOTS-1:0]   occ_r, occ_nxt;

  logic [SLOT_W-1:0]  idx_inc;
  logic               last_slot;
  logic [PROBE_W-1:0] probes_inc;
  logic               out_free;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [VALUE_W-1:0]    fval_r, fval_nxt;
  logic [PROBE_W-1:0]    pcnt_r, pcnt_nxt;
  logic [OUT_SLOT_W-1:0] oslot_r, oslot_nxt;

  // Entry memory
  logic               ram_we;
  logic               ram_re;
  logic [SLOT_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [VALUE_W-1:0] rd_value;

  lpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata ({key_r, value_r}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key   = ram_rdata[ENTRY_W-1:VALUE_W];
  assign rd_value = ram_rdata[VALUE_W-1:0];

  // Sum the masked key bytes of the incoming request
  always_comb begin
    logic [KEY_W-1:0] mk;
    mk = in_key & KEY_MASK;
    byte_sum = '0;
    for (int b = 0; b < 8; b++) begin
      byte_sum = byte_sum + SUM_W'(mk[8*b +: 8]);
    end
  end

  // Quotient estimate is exact or one low; one correction step fixes it
  assign recip_prod = (2*SUM_W)'(sum_r) * (2*SUM_W)'(RECIP);
  assign rem_raw    = sum_r - SUM_W'(quo_r * SUM_W'(SLOTS));
  assign rem_fix    = (rem_raw >= SUM_W'(SLOTS)) ? rem_raw - SUM_W'(SLOTS) : rem_raw;

  assign idx_inc    = (idx_r == SLOT_W'(SLOTS - 1)) ? '0 : idx_r + 1'b1;
  assign last_slot  = (cnt_r == SLOT_W'(SLOTS - 1));
  assign probes_inc = (probes_r == '1) ? probes_r : probes_r + 1'b1;
  assign out_free   = !out_valid_r || !out_stall;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    sum_nxt       = sum_r;
    quo_nxt       = quo_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    probes_nxt    = probes_r;
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    fval_nxt      = fval_r;
    pcnt_nxt      = pcnt_r;
    oslot_nxt     = oslot_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;

    case (state_r)
      S_IDLE: begin
        // Take a request and start its home slot
        if (in_valid) begin
          op_nxt    = in_opcode;
          key_nxt   = in_key & KEY_MASK;
          value_nxt = in_value;
          sum_nxt   = byte_sum;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        quo_nxt   = recip_prod[2*SUM_W-1:SUM_W];
        state_nxt = S_MOD;
      end
      S_MOD: begin
        idx_nxt    = rem_fix[SLOT_W-1:0];
        cnt_nxt    = '0;
        probes_nxt = '0;
        state_nxt  = (op_r == OP_INSERT) ? S_INS : S_PROBE;
      end
      S_INS: begin
        // Step over occupied slots; write the pair into the first free one
        if (out_free) begin
          if (!occ_r[idx_r]) begin
            ram_we         = 1'b1;
            occ_nxt[idx_r] = 1'b1;
            out_valid_nxt  = 1'b1;
            status_nxt     = ST_INSERTED;
            fval_nxt       = '0;
            pcnt_nxt       = '0;
            oslot_nxt      = slot_out(idx_r);
            state_nxt      = S_IDLE;
          end else if (last_slot) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_FULL;
            fval_nxt      = '0;
            pcnt_nxt      = '0;
            oslot_nxt     = '0;
            state_nxt     = S_IDLE;
          end else begin
            idx_nxt = idx_inc;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_PROBE: begin
        // Home slot: miss at once when free, else fetch the entry
        if (out_free) begin
          if (!occ_r[idx_r]) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_MISSING;
            fval_nxt      = '0;
            pcnt_nxt      = probes_r;
            oslot_nxt     = '0;
            state_nxt     = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r;
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        // Compare the fetched key; on a mismatch fetch the next slot now, unless it is free or the wrap is done
        if (out_free) begin
          if (rd_key == key_r) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_FOUND;
            fval_nxt      = rd_value;
            pcnt_nxt      = probes_inc;
            oslot_nxt     = slot_out(idx_r);
            state_nxt     = S_IDLE;
          end else if (last_slot || !occ_r[idx_inc]) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_MISSING;
            fval_nxt      = '0;
            pcnt_nxt      = probes_inc;
            oslot_nxt     = '0;
            state_nxt     = S_IDLE;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = idx_inc;
            idx_nxt    = idx_inc;
            cnt_nxt    = cnt_r + 1'b1;
            probes_nxt = probes_inc;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    value_r  <= value_nxt;
    sum_r    <= sum_nxt;
    quo_r    <= quo_nxt;
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    probes_r <= probes_nxt;
    status_r <= status_nxt;
    fval_r   <= fval_nxt;
    pcnt_r   <= pcnt_nxt;
    oslot_r  <= oslot_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_value = fval_r;
  assign out_probe_count = pcnt_r;
  assign out_slot        = oslot_r;

endmodule

// ===== rtl/lpht_checker.sv =====
module lpht_checker
  import lpht_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            out_status,
  input logic [VALUE_W-1:0]    out_found_value,
  input logic [PROBE_W-1:0]    out_probe_count,
  input logic [OUT_SLOT_W-1:0] out_slot
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_found_value) && $stable(out_probe_count) && $stable(out_slot))
    else $error("stalled result changed");

  a_insert_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_INSERTED |-> out_found_value == '0 &&
      out_probe_count == '0)
    else $error("insert result carries search fields");

  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_found_value == '0 &&
      out_probe_count == '0 && out_slot == '0)
    else $error("full result not cleared");

  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_MISSING |-> out_found_value == '0 && out_slot == '0)
    else $error("miss result carries a value or slot");

  a_found_probes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FOUND |-> out_probe_count != '0)
    else $error("hit without a key comparison");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

// ===== sim/tb_linear_probe_hash_table.sv =====
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int TOTAL_ITEMS   = DIRECTED_ROWS + RANDOM_ITEMS;
  localparam int DRAIN_CYCLES  = 64;
  localparam int CYCLE_LIMIT   = 400_000;

  typedef struct packed {
    logic [1:0]            status;
    logic [VALUE_W-1:0]    found_value;
    logic [PROBE_W-1:0]    probe_count;
    logic [OUT_SLOT_W-1:0] slot;
  } table_result_t;

  // One row of the directed table; a fixed row carries its result typed in
  typedef struct {
    logic               op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    bit                 fixed;
    table_result_t      result;
  } request_row_t;

  localparam table_result_t UNCHECKED = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_opcode = OP_INSERT;
  logic [KEY_W-1:0]      in_key = '0;
  logic [VALUE_W-1:0]    in_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_status;
  logic [VALUE_W-1:0]    out_found_value;
  logic [PROBE_W-1:0]    out_probe_count;
  logic [OUT_SLOT_W-1:0] out_slot;

  linear_probe_hash_table u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_probe_count (out_probe_count),
    .out_slot        (out_slot)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the table. Keys and values are only read where the
  // occupancy mark is set, so they need no reset value.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]   shadow_keys   [SLOTS];
  logic [VALUE_W-1:0] shadow_values [SLOTS];
  bit                 shadow_used   [SLOTS] = '{default: 1'b0};

  table_result_t due_results [$];   // results owed by the block, oldest first

  request_row_t stim_table [DIRECTED_ROWS];

  int  requests_made  = 0;   // requests placed on the input port
  int  requests_taken = 0;   // requests the block has accepted
  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  idle_phase     = 0;   // selects the idle/stall mix, see pct functions

  bit            cur_fixed;
  table_result_t cur_expect;

  // Walk the shadow table for one request and return what the block owes.
  // Inserts land in the first free slot from home; searches stop on a match,
  // a free slot or after one full wrap.
  function automatic table_result_t probe_table(logic op, logic [KEY_W-1:0] key_in,
                                                logic [VALUE_W-1:0] val);
    logic [KEY_W-1:0] k;
    int unsigned      sum;
    int unsigned      idx;
    bit               done;
    table_result_t    r;
    k    = key_in & KEY_MASK;
    sum  = 0;
    done = 1'b0;
    r    = '0;
    for (int b = 0; b < 8; b++) sum += k[8*b +: 8];
    idx = sum % SLOTS;
    if (op == OP_INSERT) begin
      r.status = ST_FULL;
      for (int n = 0; n < SLOTS && !done; n++) begin
        if (!shadow_used[idx]) begin
          shadow_keys[idx]   = k;
          shadow_values[idx] = val;
          shadow_used[idx]   = 1'b1;
          r.status = ST_INSERTED;
          r.slot   = idx[OUT_SLOT_W-1:0];
          done     = 1'b1;
        end else begin
          idx = (idx + 1) % SLOTS;
        end
      end
    end else begin
      r.status = ST_MISSING;
      for (int n = 0; n < SLOTS && !done; n++) begin
        if (!shadow_used[idx]) begin
          done = 1'b1;
        end else begin
          if (r.probe_count != 5'd31) r.probe_count++;
          if (shadow_keys[idx] == k) begin
            r.status      = ST_FOUND;
            r.found_value = shadow_values[idx];
            r.slot        = idx[OUT_SLOT_W-1:0];
            done          = 1'b1;
          end else begin
            idx = (idx + 1) % SLOTS;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic table_result_t outcome(logic [1:0] st, logic [VALUE_W-1:0] fv,
                                            logic [PROBE_W-1:0] pc,
                                            logic [OUT_SLOT_W-1:0] sl);
    table_result_t r;
    r.status      = st;
    r.found_value = fv;
    r.probe_count = pc;
    r.slot        = sl;
    return r;
  endfunction

  function automatic request_row_t row(logic op, logic [KEY_W-1:0] k,
                                       logic [VALUE_W-1:0] v, bit fixed,
                                       table_result_t r);
    request_row_t t;
    t.op     = op;
    t.key    = k;
    t.value  = v;
    t.fixed  = fixed;
    t.result = r;
    return t;
  endfunction

  // Directed rows. The order matters: the table only fills, never empties,
  // so each row sees the state left by the ones above it.
  initial begin
    // empty table: search misses without a single comparison
    stim_table[0]  = row(OP_SEARCH, 64'h0, 32'h0, 1'b1, outcome(ST_MISSING, 32'h0, 5'd0, 4'd0));
    // extremes of key and value; all-ones key sums to 2040, home slot 8
    stim_table[1]  = row(OP_INSERT, 64'h0, 32'hFFFF_FFFF, 1'b1,
                         outcome(ST_INSERTED, 32'h0, 5'd0, 4'd0));
    stim_table[2]  = row(OP_INSERT, '1, 32'h0, 1'b1, outcome(ST_INSERTED, 32'h0, 5'd0, 4'd8));
    stim_table[3]  = row(OP_SEARCH, 64'h0, 32'h1234_5678, 1'b1,
                         outcome(ST_FOUND, 32'hFFFF_FFFF, 5'd1, 4'd0));
    stim_table[4]  = row(OP_SEARCH, '1, 32'h0, 1'b1, outcome(ST_FOUND, 32'h0, 5'd1, 4'd8));
    // duplicate key is stored again; a search still hits the first copy
    stim_table[5]  = row(OP_INSERT, 64'h0, 32'h0000_1234, 1'b0, UNCHECKED);
    // collision on home slot 0, then a hit and a miss behind the run
    stim_table[6]  = row(OP_INSERT, 64'h10, 32'h8000_0001, 1'b0, UNCHECKED);
    stim_table[7]  = row(OP_SEARCH, 64'h10, 32'h0, 1'b0, UNCHECKED);
    stim_table[8]  = row(OP_SEARCH, 64'h20, 32'h0, 1'b0, UNCHECKED);
    // home slot 15: the second insert wraps round past slot 0
    stim_table[9]  = row(OP_INSERT, 64'h0F, 32'h7FFF_FFFE, 1'b0, UNCHECKED);
    stim_table[10] = row(OP_INSERT, 64'h1F, 32'h5555_AAAA, 1'b0, UNCHECKED);
    stim_table[11] = row(OP_SEARCH, 64'h1F, 32'h0, 1'b0, UNCHECKED);
    stim_table[12] = row(OP_SEARCH, 64'h2F, 32'h0, 1'b0, UNCHECKED);
    // fill the rest of the table
    stim_table[13] = row(OP_INSERT, 64'h8000_0000_0000_0000, 32'h0000_0001, 1'b0, UNCHECKED);
    stim_table[14] = row(OP_INSERT, 64'h0102_0304_0506_0708, 32'hA5A5_5A5A, 1'b0, UNCHECKED);
    stim_table[15] = row(OP_INSERT, 64'hDEAD_BEEF_CAFE_F00D, 32'h1357_9BDF, 1'b0, UNCHECKED);
    stim_table[16] = row(OP_INSERT, 64'h0000_0000_0000_0101, 32'h2468_ACE0, 1'b0, UNCHECKED);
    stim_table[17] = row(OP_INSERT, 64'h0000_0000_0000_1001, 32'hFFFF_0000, 1'b0, UNCHECKED);
    stim_table[18] = row(OP_INSERT, 64'h0100_0000_0000_0010, 32'h0000_FFFF, 1'b0, UNCHECKED);
    stim_table[19] = row(OP_INSERT, 64'h7F7F_7F7F_7F7F_7F7F, 32'hC3C3_3C3C, 1'b0, UNCHECKED);
    stim_table[20] = row(OP_INSERT, 64'h0000_0000_FFFF_FFFF, 32'h8421_1248, 1'b0, UNCHECKED);
    stim_table[21] = row(OP_INSERT, 64'hFEDC_BA98_7654_3210, 32'h0F0F_F0F0, 1'b0, UNCHECKED);
    stim_table[22] = row(OP_INSERT, 64'h00FF_00FF_00FF_00FF, 32'hF00D_CAFE, 1'b0, UNCHECKED);
    // full table: insert is refused, a missing key costs one full wrap
    stim_table[23] = row(OP_INSERT, 64'h1234, 32'hFFFF_FFFF, 1'b1,
                         outcome(ST_FULL, 32'h0, 5'd0, 4'd0));
    stim_table[24] = row(OP_SEARCH, 64'h30, 32'h0, 1'b1, outcome(ST_MISSING, 32'h0, 5'd16, 4'd0));
  end

  function automatic int send_idle_pct(int phase);
    case (phase)
      1:       return 65;
      3:       return 32;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(int phase);
    case (phase)
      2:       return 65;
      3:       return 32;
      default: return 0;
    endcase
  endfunction

  // Key of some occupied slot, found from a random starting point
  function automatic logic [KEY_W-1:0] stored_key();
    int unsigned idx;
    idx = $urandom_range(SLOTS - 1);
    for (int n = 0; n < SLOTS; n++) begin
      if (shadow_used[idx]) return shadow_keys[idx];
      idx = (idx + 1) % SLOTS;
    end
    return {$urandom, $urandom};
  endfunction

  // Next request: directed rows first, then random ones. By then the table
  // is full, so half of the random requests search for stored keys (hits at every
  // probe depth) and the rest are near-misses, noise and refused inserts.
  task automatic build_request(output logic op, output logic [KEY_W-1:0] k,
                               output logic [VALUE_W-1:0] v);
    int unsigned pick;
    int unsigned a;
    int unsigned b;
    logic [7:0]  t;
    if (requests_made < DIRECTED_ROWS) begin
      op         = stim_table[requests_made].op;
      k          = stim_table[requests_made].key;
      v          = stim_table[requests_made].value;
      cur_fixed  = stim_table[requests_made].fixed;
      cur_expect = stim_table[requests_made].result;
    end else begin
      cur_fixed  = 1'b0;
      cur_expect = UNCHECKED;
      pick = $urandom_range(99);
      op   = OP_SEARCH;
      v    = $urandom;
      k    = stored_key();
      if (pick < 50) begin
        // plain hit
      end else if (pick < 62) begin
        // flip one bit: usually a miss after a full wrap
        a = $urandom_range(KEY_W - 1);
        k[a] = ~k[a];
      end else if (pick < 72) begin
        // swap two bytes: same home slot, usually a different key
        a = $urandom_range(7);
        b = $urandom_range(7);
        t = k[8*a +: 8];
        k[8*a +: 8] = k[8*b +: 8];
        k[8*b +: 8] = t;
      end else if (pick < 82) begin
        k = {$urandom, $urandom};
      end else if (pick < 91) begin
        op = OP_INSERT;
        k  = {$urandom, $urandom};
      end else begin
        op = OP_INSERT;   // duplicate insert into a full table
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request side: hold a presented request until accepted, then either
  // present the next one or idle with noise on the payload.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    logic               took;
    logic               op;
    logic [KEY_W-1:0]   k;
    logic [VALUE_W-1:0] v;
    table_result_t      predicted;
    table_result_t      owed;
    took = in_valid && !in_stall;
    if (took) begin
      // advance the shadow table with what the block just took
      predicted   = probe_table(in_opcode, in_key, in_value);
      owed        = cur_fixed ? cur_expect : predicted;
      due_results = {due_results, owed};
      requests_taken++;
    end
    if (rst_n && !(in_valid && !took)) begin
      if (requests_made < TOTAL_ITEMS &&
          $urandom_range(99) >= send_idle_pct(idle_phase)) begin
        build_request(op, k, v);
        in_valid  <= 1'b1;
        in_opcode <= op;
        in_key    <= k;
        in_value  <= v;
        requests_made++;
        idle_phase <= requests_made * 4 / TOTAL_ITEMS;
      end else begin
        in_valid  <= 1'b0;
        in_opcode <= 1'($urandom_range(1));
        in_key    <= {$urandom, $urandom};
        in_value  <= $urandom;
      end
    end
  end

  task automatic log_mismatch(string what, table_result_t want, table_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $write("%s: expected status %0d value %h probes %0d slot %0d, ",
             what, want.status, want.found_value, want.probe_count, want.slot);
      $display("got status %0d value %h probes %0d slot %0d",
               got.status, got.found_value, got.probe_count, got.slot);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check every accepted result against the oldest one owed,
  // and stall at random according to the current phase.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    table_result_t got;
    table_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = outcome(out_status, out_found_value, out_probe_count, out_slot);
      if (due_results.size() == 0) begin
        log_mismatch("result with no request pending", UNCHECKED, got);
      end else begin
        want = due_results.pop_front();
        if (got.status !== want.status || got.found_value !== want.found_value ||
            got.probe_count !== want.probe_count || got.slot !== want.slot)
          log_mismatch("result differs", want, got);
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct(idle_phase));
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Stop a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("linear_probe_hash_table: mismatch");
    $finish;
  end

  // Reset once, then wait for every request to be taken and answered
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (!(requests_taken == TOTAL_ITEMS && due_results.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0)
      $display("linear_probe_hash_table: match");
    else
      $display("linear_probe_hash_table: mismatch");
    $finish;
  end

endmodule
